// ===== src/front_coding_word_encoder_macros.svh =====
// Assertion macros used by the front-coding encoder checker
`ifndef FRONT_CODING_WORD_ENCODER_MACROS_SVH
`define FRONT_CODING_WORD_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FCWE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcwe: same-cycle check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define FCWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcwe: next-cycle check failed");

`endif

// ===== src/fcwe_pkg.sv =====
// Types and constants for the front-coding word encoder
`default_nettype none

package fcwe_pkg;

    localparam int PREFIX_CAP = 9;
    localparam int HEAD_DEPTH = 9;
    localparam int POS_W      = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_EOW  = 2'd1;
    localparam logic [1:0] MODE_EOL  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] in_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       list_done;
    } out_t;

    // results produced by one input word, in order
    typedef struct packed {
        logic [1:0] count;
        out_t       res0;
        out_t       res1;
    } push_t;

endpackage

`default_nettype wire

// ===== src/fcwe_core.sv =====
// Front-coding state and per-word result generation
`default_nettype none

module fcwe_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire fcwe_pkg::in_t item,
    output fcwe_pkg::push_t    push
);

    logic [7:0]                 prev_head_reg [fcwe_pkg::HEAD_DEPTH];
    logic [fcwe_pkg::POS_W-1:0] prev_len_reg, prev_len_next;
    logic [fcwe_pkg::POS_W-1:0] word_pos_reg, word_pos_next;
    logic                       first_word_reg, first_word_next;
    logic                       digit_sent_reg, digit_sent_next;

    logic                       pos_in_head;
    logic [7:0]                 head_byte;
    logic                       prefix_hit;
    logic [7:0]                 digit;
    logic                       head_we;

    assign pos_in_head = word_pos_reg < fcwe_pkg::POS_W'(fcwe_pkg::HEAD_DEPTH);
    assign head_byte   = pos_in_head ? prev_head_reg[word_pos_reg] : 8'h00;
    assign prefix_hit  = (word_pos_reg < fcwe_pkg::POS_W'(fcwe_pkg::PREFIX_CAP))
                      && (word_pos_reg < prev_len_reg)
                      && (head_byte == item.in_byte);
    assign digit       = fcwe_pkg::ASCII_ZERO + {4'b0000, word_pos_reg};
    assign head_we     = fire && (item.mode == fcwe_pkg::MODE_BYTE) && pos_in_head;

    always_comb
    begin
        push            = '0;
        prev_len_next   = prev_len_reg;
        word_pos_next   = word_pos_reg;
        first_word_next = first_word_reg;
        digit_sent_next = digit_sent_reg;
        if (fire)
        begin
            case (item.mode)
                fcwe_pkg::MODE_BYTE:
                begin
                    if (first_word_reg || digit_sent_reg)
                    begin
                        push.count = 2'd1;
                        push.res0  = '{out_byte: item.in_byte, run_last: 1'b1,
                                       list_done: 1'b0};
                    end
                    else if (!prefix_hit)
                    begin
                        push.count      = 2'd2;
                        push.res0       = '{out_byte: digit, run_last: 1'b0,
                                            list_done: 1'b0};
                        push.res1       = '{out_byte: item.in_byte, run_last: 1'b1,
                                            list_done: 1'b0};
                        digit_sent_next = 1'b1;
                    end
                    if (pos_in_head)
                        word_pos_next = word_pos_reg + fcwe_pkg::POS_W'(1);
                end
                fcwe_pkg::MODE_EOW:
                begin
                    if (!first_word_reg && !digit_sent_reg)
                    begin
                        push.count = 2'd1;
                        push.res0  = '{out_byte: digit, run_last: 1'b1, list_done: 1'b0};
                    end
                    prev_len_next   = word_pos_reg;
                    word_pos_next   = '0;
                    digit_sent_next = 1'b0;
                    first_word_next = 1'b0;
                end
                fcwe_pkg::MODE_EOL:
                begin
                    // an open later word still owes its digit before the terminator
                    if ((word_pos_reg != '0) && !first_word_reg && !digit_sent_reg)
                    begin
                        push.count = 2'd2;
                        push.res0  = '{out_byte: digit, run_last: 1'b0, list_done: 1'b0};
                        push.res1  = '{out_byte: fcwe_pkg::ASCII_ZERO, run_last: 1'b1,
                                       list_done: 1'b1};
                    end
                    else
                    begin
                        push.count = 2'd1;
                        push.res0  = '{out_byte: fcwe_pkg::ASCII_ZERO, run_last: 1'b1,
                                       list_done: 1'b1};
                    end
                    prev_len_next   = '0;
                    word_pos_next   = '0;
                    digit_sent_next = 1'b0;
                    first_word_next = 1'b1;
                end
                default:
                begin
                    push.count = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_len_reg   <= '0;
            word_pos_reg   <= '0;
            first_word_reg <= 1'b1;
            digit_sent_reg <= 1'b0;
        end
        else
        begin
            prev_len_reg   <= prev_len_next;
            word_pos_reg   <= word_pos_next;
            first_word_reg <= first_word_next;
            digit_sent_reg <= digit_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            prev_head_reg[word_pos_reg] <= item.in_byte;
    end

endmodule

`default_nettype wire

// ===== src/fcwe_out_fifo.sv =====
// Small result queue taking up to two results per cycle
`default_nettype none

module fcwe_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fcwe_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output fcwe_pkg::out_t       out_data
);

    fcwe_pkg::out_t             fifo_mem_reg [fcwe_pkg::FIFO_DEPTH];
    logic [fcwe_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fcwe_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fcwe_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       pop;
    logic [fcwe_pkg::PTR_W-1:0] wr_ptr_plus1;

    assign out_valid    = count_reg != '0;
    assign out_data     = fifo_mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // room for a worst-case pair of results
    assign room         = count_reg <= fcwe_pkg::CNT_W'(fcwe_pkg::FIFO_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + fcwe_pkg::PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + fcwe_pkg::PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + fcwe_pkg::PTR_W'(pop);
        count_next  = count_reg + fcwe_pkg::CNT_W'(push.count)
                    - fcwe_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            fifo_mem_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            fifo_mem_reg[wr_ptr_plus1] <= push.res1;
    end

endmodule

`default_nettype wire

// ===== src/front_coding_word_encoder.sv =====
// A word is registered in item_reg, then its results go to the four-entry
// result queue. Throughput: one input word per cycle while the queue has
// room; two-result words (prefix digit plus byte, digit plus terminator)
// drain one a cycle while out_ready is high and hold back the input side.
// Reset (rst_n, async low): queue empty, no previous word, next word first.
`default_nettype none

module front_coding_word_encoder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fcwe_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fcwe_pkg::out_t      out_data
);

    fcwe_pkg::in_t   item_reg;
    logic            item_valid_reg;
    logic            room;
    logic            advance;
    fcwe_pkg::push_t push;

    assign advance  = item_valid_reg && room;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    fcwe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .push  (push)
    );

    fcwe_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/fcwe_checker.sv =====
// Port-level checks for the front-coding word encoder, bound to the top level
`default_nettype none

`include "front_coding_word_encoder_macros.svh"

module fcwe_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire fcwe_pkg::out_t out_data
);

    // a stalled result holds
    `FCWE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // terminator is always '0' and closes its word's results
    `FCWE_ASSERT_NOW(a_done_is_zero, out_valid && out_data.list_done,
        out_data.out_byte == fcwe_pkg::ASCII_ZERO && out_data.run_last)

    // with nothing queued the input side never stalls
    `FCWE_ASSERT_NOW(a_idle_ready, !out_valid, in_ready)

    // the partner of a result pair is queued together with it
    `FCWE_ASSERT_NEXT(a_pair_follows, out_valid && !out_data.run_last, out_valid)

endmodule

bind front_coding_word_encoder fcwe_checker u_checker (.*);

`default_nettype wire
